[rtl/core/solt_pkg.sv]
// Package for the shared object label table: sizes, hash constant, command codes
// and the layout of one slot entry. It has no dependencies.
package solt_pkg;

    // Table geometry (TABLE_SIZE is a power of two, so the home slot is a mask)
    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int KEY_W      = 32;
    localparam int LABEL_W    = 9;
    localparam int CMD_W      = 2;

    // Multiplicative hash constant
    localparam logic [KEY_W-1:0] GOLDEN_MULT = 32'd2654435761;

    // Highest label; the label counter saturates here
    localparam logic [LABEL_W-1:0] LABEL_MAX = {LABEL_W{1'b1}};

    // Command codes
    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_VISIT = 2'd0;
    localparam t_cmd CMD_QUERY = 2'd1;
    localparam t_cmd CMD_CLEAR = 2'd2;

    // One slot of the key store
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic               shared;
        logic [LABEL_W-1:0] label;
    } t_slot_entry;

endpackage

[rtl/core/shared_object_label_table.sv]
// Shared object label table: linear probing hash table with a multiplicative hash.
// Depends on solt_pkg for sizes, command codes and the slot entry layout.
//
// A clear or unused command returns its result in the cycle after transfer; a
// visit or query steps through the hash, read and check states, with a further
// read and check per extra slot probed. Busy stays high until the result cycle,
// so no new item is taken before the last is done; each probe is a slot-store read then a key compare.
// Reset: synchronous, active low; empties the table at once (valid bits in
// flip-flops) and sets the next label to 1. The receiver cannot stall results.
module shared_object_label_table
    import solt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [KEY_W-1:0]   i_key,
    output logic               o_done,
    output logic               o_was_present,
    output logic [LABEL_W-1:0] o_label,
    output logic               o_label_new,
    output logic               o_status
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_HASH  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CHECK = 4'b1000
    } t_state;

    t_state             r_state;
    t_cmd               r_cmd;
    logic [KEY_W-1:0]   r_key;
    logic [IDX_W-1:0]   r_slot;
    logic [IDX_W-1:0]   r_probe_cnt;
    logic [TABLE_SIZE-1:0] r_slot_valid;
    logic               r_rd_valid;
    t_slot_entry        r_rd_entry;
    logic [LABEL_W-1:0] r_next_label;

    logic               r_done;
    logic               r_was_present;
    logic [LABEL_W-1:0] r_label;
    logic               r_label_new;
    logic               r_status;

    t_slot_entry        slot_mem [TABLE_SIZE];

    logic [KEY_W-1:0]   hash;
    logic               hit;
    logic               need_label;
    logic               mem_we;
    t_slot_entry        mem_wdata;

    // Hash the held key; only the low bits pick the home slot
    assign hash = r_key * GOLDEN_MULT;

    // Compare the fetched slot against the key
    assign hit        = r_rd_valid && (r_rd_entry.key == r_key);
    assign need_label = hit && (r_cmd == CMD_QUERY) && r_rd_entry.shared &&
                        (r_rd_entry.label == LABEL_W'(0));

    // Build the slot write for insert, mark-shared and label assignment
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rd_entry;
        if (r_state == ST_CHECK) begin
            if (!r_rd_valid && (r_cmd == CMD_VISIT)) begin
                mem_we    = 1'b1;
                mem_wdata = '{key: r_key, shared: 1'b0, label: '0};
            end else if (hit && (r_cmd == CMD_VISIT)) begin
                mem_we           = 1'b1;
                mem_wdata.shared = 1'b1;
            end else if (need_label) begin
                mem_we          = 1'b1;
                mem_wdata.label = r_next_label;
            end
        end
    end

    // Slot store: one write and one registered read at the probe slot
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            slot_mem[r_slot] <= mem_wdata;
        end
        r_rd_entry <= slot_mem[r_slot];
    end

    // Sequencer: hash, then read and compare one slot per probe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_slot_valid <= '0;
            r_next_label <= LABEL_W'(1);
            r_done       <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_cmd <= i_cmd;
                        r_key <= i_key;
                        if ((i_cmd == CMD_VISIT) || (i_cmd == CMD_QUERY)) begin
                            r_state <= ST_HASH;
                        end else begin
                            // Clear or unused command: answer with all zero
                            if (i_cmd == CMD_CLEAR) begin
                                r_slot_valid <= '0;
                                r_next_label <= LABEL_W'(1);
                            end
                            r_done        <= 1'b1;
                            r_was_present <= 1'b0;
                            r_label       <= '0;
                            r_label_new   <= 1'b0;
                            r_status      <= 1'b0;
                        end
                    end
                end
                ST_HASH: begin
                    r_slot      <= hash[IDX_W-1:0];
                    r_probe_cnt <= '0;
                    r_state     <= ST_READ;
                end
                ST_READ: begin
                    r_rd_valid <= r_slot_valid[r_slot];
                    r_state    <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_was_present <= 1'b0;
                    r_label       <= '0;
                    r_label_new   <= 1'b0;
                    r_status      <= 1'b0;
                    if (!r_rd_valid) begin
                        // Free slot ends the probe; a visit inserts here
                        if (r_cmd == CMD_VISIT) begin
                            r_slot_valid[r_slot] <= 1'b1;
                        end
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (hit) begin
                        r_was_present <= 1'b1;
                        if ((r_cmd == CMD_QUERY) && r_rd_entry.shared) begin
                            if (need_label) begin
                                r_label     <= r_next_label;
                                r_label_new <= 1'b1;
                                if (r_next_label != LABEL_MAX) begin
                                    r_next_label <= r_next_label + LABEL_W'(1);
                                end
                            end else begin
                                r_label <= r_rd_entry.label;
                            end
                        end
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (r_probe_cnt == IDX_LAST) begin
                        // Every slot probed without a match or a free slot
                        r_status <= (r_cmd == CMD_VISIT);
                        r_done   <= 1'b1;
                        r_state  <= ST_IDLE;
                    end else begin
                        // Advance to the next slot, wrapping
                        r_slot      <= r_slot + IDX_W'(1);
                        r_probe_cnt <= r_probe_cnt + IDX_W'(1);
                        r_state     <= ST_READ;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Drive the result ports
    assign busy          = (r_state != ST_IDLE);
    assign o_done        = r_done;
    assign o_was_present = r_was_present;
    assign o_label       = r_label;
    assign o_label_new   = r_label_new;
    assign o_status      = r_status;

endmodule

[tb/tb_shared_object_label_table.sv]
// Testbench for shared_object_label_table: directed and random visit, query and clear traffic
// checked against an in-bench model of the hash table. Depends on solt_pkg and the block RTL.
module tb_shared_object_label_table
    import solt_pkg::*;
();

    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam int   ITEM_TARGET = 650;
    localparam int   TAIL_CYCLES = 2 * TABLE_SIZE + 16;
    localparam int   RUN_LIMIT   = 40_000_000;

    // One expected result, with the transfer that caused it kept for messages
    typedef struct {
        t_cmd               cmd;
        logic [KEY_W-1:0]   key;
        logic               was_present;
        logic [LABEL_W-1:0] label;
        logic               label_new;
        logic               status;
    } t_label_result;

    // Hash table model plus the queue of results still owed by the block
    class label_table_model;
        bit                 slot_used[TABLE_SIZE];
        logic [KEY_W-1:0]   slot_key[TABLE_SIZE];
        bit                 slot_shared[TABLE_SIZE];
        logic [LABEL_W-1:0] slot_label[TABLE_SIZE];
        logic [LABEL_W-1:0] next_label;
        int                 entry_count;
        t_label_result      pending_results[$];
        int                 mismatch_count;

        function new();
            mismatch_count = 0;
            empty_table();
        endfunction

        function void empty_table();
            foreach (slot_used[i]) slot_used[i] = 0;
            next_label  = 1;
            entry_count = 0;
        endfunction

        // Walk linearly from the home slot; stop at the key or at the first free slot
        function bit find_key(input logic [KEY_W-1:0] k, output int hit_idx,
                              output int free_idx);
            logic [KEY_W-1:0] h;
            logic [IDX_W-1:0] s;
            h        = k * GOLDEN_MULT;
            hit_idx  = -1;
            free_idx = -1;
            for (int i = 0; i < TABLE_SIZE; i++) begin
                s = h[IDX_W-1:0] + IDX_W'(i);
                if (!slot_used[s]) begin
                    free_idx = s;
                    return 0;
                end
                if (slot_key[s] == k) begin
                    hit_idx = s;
                    return 1;
                end
            end
            return 0;
        endfunction

        // Apply one accepted transfer and queue the result it owes
        function void note_transfer(t_cmd c, logic [KEY_W-1:0] k);
            t_label_result r;
            int            hit_idx;
            int            free_idx;
            bit            found;
            r.cmd         = c;
            r.key         = k;
            r.was_present = 0;
            r.label       = '0;
            r.label_new   = 0;
            r.status      = 0;
            case (c)
                CMD_VISIT: begin
                    found = find_key(k, hit_idx, free_idx);
                    if (found) begin
                        slot_shared[hit_idx] = 1;
                        r.was_present        = 1;
                    end else if (free_idx >= 0) begin
                        slot_used[free_idx]   = 1;
                        slot_key[free_idx]    = k;
                        slot_shared[free_idx] = 0;
                        slot_label[free_idx]  = '0;
                        entry_count++;
                    end else begin
                        r.status = 1;
                    end
                end
                CMD_QUERY: begin
                    found = find_key(k, hit_idx, free_idx);
                    if (found) begin
                        r.was_present = 1;
                        if (slot_shared[hit_idx]) begin
                            if (slot_label[hit_idx] == '0) begin
                                slot_label[hit_idx] = next_label;
                                r.label_new         = 1;
                                if (next_label < LABEL_MAX) next_label++;
                            end
                            r.label = slot_label[hit_idx];
                        end
                    end
                end
                CMD_CLEAR: begin
                    empty_table();
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void note_mismatch(string msg);
            mismatch_count++;
            if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic wp, logic [LABEL_W-1:0] lb, logic ln, logic st);
            t_label_result e;
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf(
                    "result with none expected: present %0d label %0d new %0d full %0d",
                    wp, lb, ln, st));
                return;
            end
            e = pending_results.pop_front();
            if (wp !== e.was_present || lb !== e.label || ln !== e.label_new ||
                st !== e.status) begin
                note_mismatch($sformatf({"cmd %0d key %h: expected present %0d label %0d ",
                                         "new %0d full %0d, got %0d %0d %0d %0d"},
                    e.cmd, e.key, e.was_present, e.label, e.label_new, e.status,
                    wp, lb, ln, st));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd;
    logic [KEY_W-1:0]   i_key;
    logic               o_done;
    logic               o_was_present;
    logic [LABEL_W-1:0] o_label;
    logic               o_label_new;
    logic               o_status;

    label_table_model   labels;
    int                 items_sent;
    int                 burst_left;

    shared_object_label_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .o_done        (o_done),
        .o_was_present (o_was_present),
        .o_label       (o_label),
        .o_label_new   (o_label_new),
        .o_status      (o_status)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Check every strobed result at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            labels.check_result(o_was_present, o_label, o_label_new, o_status);
    end

    // Key with random upper bits whose hash lands on the given home slot
    function automatic logic [KEY_W-1:0] key_with_home(logic [IDX_W-1:0] home);
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] h;
        k = $urandom;
        for (int b = 0; b < TABLE_SIZE; b++) begin
            k[IDX_W-1:0] = IDX_W'(b);
            h = k * GOLDEN_MULT;
            if (h[IDX_W-1:0] == home) return k;
        end
        return k;
    endfunction

    // Offer one item, idling between bursts, and hold it until the transfer
    task automatic send_item(t_cmd c, logic [KEY_W-1:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        i_key <= k;
        do @(posedge i_clk); while (busy);
        labels.note_transfer(c, k);
        items_sent++;
    endtask

    // Drop start and hold off until every owed result is in
    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (labels.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Mostly visits and queries over a small key pool, part of it piled on one home slot
    task automatic run_mixed_phase();
        logic [KEY_W-1:0] pool[$];
        logic [KEY_W-1:0] k;
        logic [IDX_W-1:0] hot;
        int               n_keys;
        int               n_items;
        int               pick;
        hot    = IDX_W'($urandom);
        n_keys = $urandom_range(4, 40);
        repeat (n_keys) begin
            if ($urandom_range(0, 2) == 0) pool.push_back(key_with_home(hot));
            else pool.push_back($urandom);
        end
        n_items = $urandom_range(15, 60);
        if ($urandom_range(0, 1) == 1) send_item(CMD_CLEAR, $urandom);
        repeat (n_items) begin
            k    = pool[$urandom_range(0, pool.size() - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 45)      send_item(CMD_VISIT, k);
            else if (pick < 88) send_item(CMD_QUERY, k);
            else if (pick < 92) send_item(CMD_VISIT, $urandom);
            else if (pick < 95) send_item(CMD_QUERY, $urandom);
            else if (pick < 98) send_item(CMD_UNUSED, $urandom);
            else                send_item(CMD_CLEAR, k);
        end
    endtask

    // Fill every slot, then poke the full table
    task automatic run_fill_phase();
        logic [KEY_W-1:0] filled[$];
        logic [KEY_W-1:0] k;
        send_item(CMD_CLEAR, $urandom);
        while (labels.entry_count < TABLE_SIZE) begin
            k = $urandom;
            filled.push_back(k);
            send_item(CMD_VISIT, k);
        end
        repeat (3) send_item(CMD_VISIT, $urandom);
        repeat (4) begin
            k = filled[$urandom_range(0, filled.size() - 1)];
            send_item(CMD_VISIT, k);
            send_item(CMD_QUERY, k);
        end
        send_item(CMD_QUERY, $urandom);
        drain_results();
        send_item(CMD_CLEAR, $urandom);
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [KEY_W-1:0] wrap_key[4];
        bit               fill_done;
        labels     = new();
        items_sent = 0;
        burst_left = 0;
        fill_done  = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_VISIT;
        i_key      = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme keys, every command, label order, wrapping probe, clear
        foreach (wrap_key[i]) wrap_key[i] = key_with_home(IDX_W'(TABLE_SIZE - 1));
        send_item(CMD_QUERY, '0);
        send_item(CMD_VISIT, '0);
        send_item(CMD_QUERY, '0);
        send_item(CMD_VISIT, '0);
        send_item(CMD_QUERY, '0);
        send_item(CMD_QUERY, '0);
        send_item(CMD_VISIT, '1);
        send_item(CMD_VISIT, '1);
        send_item(CMD_VISIT, '0);
        send_item(CMD_QUERY, '1);
        send_item(CMD_QUERY, '0);
        send_item(CMD_UNUSED, '1);
        send_item(CMD_VISIT, wrap_key[0]);
        send_item(CMD_VISIT, wrap_key[1]);
        send_item(CMD_VISIT, wrap_key[2]);
        send_item(CMD_VISIT, wrap_key[2]);
        send_item(CMD_QUERY, wrap_key[2]);
        send_item(CMD_QUERY, wrap_key[3]);
        drain_results();
        send_item(CMD_CLEAR, '1);
        send_item(CMD_QUERY, '0);
        send_item(CMD_VISIT, '0);
        send_item(CMD_VISIT, '0);
        send_item(CMD_QUERY, '0);

        // Random phases, with one full-table phase once the table has seen some use
        while (items_sent < ITEM_TARGET) begin
            if (!fill_done && items_sent > 150) begin
                run_fill_phase();
                fill_done = 1;
            end else begin
                run_mixed_phase();
                if ($urandom_range(0, 1) == 1) drain_results();
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (labels.mismatch_count == 0 && labels.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
